### rtl/core/refcounted_block_pool_allocator_macros.svh
// assertion helpers for the block pool allocator
`ifndef REFCOUNTED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define REFCOUNTED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define RBPA_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define RBPA_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

### rtl/core/rbpa_pkg.sv
package rbpa_pkg;

   typedef enum logic [1:0] {
      OP_INIT    = 2'd0,
      OP_ALLOC   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_ADDREF  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_OOM     = 3'd1,
      ST_FREED   = 3'd2,
      ST_DROPPED = 3'd3,
      ST_BAD     = 3'd4,
      ST_SAT     = 3'd5
   } status_type;

   localparam logic [8:0] COUNT_LIMIT  = 9'd511;
   localparam logic [8:0] TOTAL_RESET  = 9'd256;
   localparam logic [7:0] REF_LIMIT    = 8'hFF;

   // controller to datapath
   typedef struct packed {
      logic capture;   // take the item and issue the memory read
      logic sweep;     // write one entry of the initialize sweep
      logic exec;      // apply the item and load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_is_init;
      logic init_zero;
      logic sweep_last;
      logic out_free;
   } stat_type;

endpackage

### rtl/core/rbpa_ctrl.sv
module rbpa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  rbpa_pkg::stat_type stat,
   output rbpa_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SWEEP,
      S_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // no item is taken while reset is high
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.capture = 1'b1;
               if (stat.req_is_init && !stat.init_zero) begin
                  state_in = S_SWEEP;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold here while the previous result is still waiting
            if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/rbpa_datapath.sv
module rbpa_datapath #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  rbpa_pkg::cmd_type  cmd,
   output rbpa_pkg::stat_type stat,
   input  logic [15:0]        req_tdata,
   input  logic               csr_wr_en,
   input  logic [8:0]         csr_wr_data,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [31:0]        rsp_tdata
);

   localparam int DEPTH = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // memories: link entry is {list end, next block}
   logic [8:0] link_mem [DEPTH];
   logic [7:0] ref_mem  [DEPTH];

   logic [8:0]          total_ff;
   logic [8:0]          pool_ff;
   logic [7:0]          head_ff, head_in;
   logic                empty_ff, empty_in;
   logic [8:0]          in_use_ff, in_use_in;
   logic [8:0]          peak_ff, peak_in;
   rbpa_pkg::op_type    op_ff;
   logic [7:0]          idx_ff;
   logic [7:0]          sweep_ff;
   logic [8:0]          link_q_ff;
   logic [7:0]          ref_q_ff;
   logic                rsp_valid_ff;
   logic [7:0]          granted_ff, granted_in;
   rbpa_pkg::status_type status_ff, status_in;

   rbpa_pkg::op_type    req_op;
   logic [7:0]          req_idx;
   logic [8:0]          init_size;
   logic [AW-1:0]       rd_addr;
   logic                sweep_end;
   logic                bad_idx;
   logic [8:0]          in_inc, in_dec;

   logic                link_we;
   logic [AW-1:0]       link_wa;
   logic [8:0]          link_wd;
   logic                ref_we;
   logic [AW-1:0]       ref_wa;
   logic [7:0]          ref_wd;

   assign req_op  = rbpa_pkg::op_type'(req_tdata[1:0]);
   assign req_idx = req_tdata[9:2];

   // pool size clamps to the memory depth
   assign init_size = (total_ff > 9'(DEPTH)) ? 9'(DEPTH) : total_ff;

   assign rd_addr = (req_op == rbpa_pkg::OP_ALLOC) ? head_ff[AW-1:0] : req_idx[AW-1:0];

   assign sweep_end = (({1'b0, sweep_ff} + 9'd1) == pool_ff);
   assign bad_idx   = ({1'b0, idx_ff} >= pool_ff);
   assign in_inc    = (in_use_ff == rbpa_pkg::COUNT_LIMIT) ? in_use_ff : in_use_ff + 9'd1;
   assign in_dec    = (in_use_ff == 9'd0) ? in_use_ff : in_use_ff - 9'd1;

   assign stat.req_is_init = (req_op == rbpa_pkg::OP_INIT);
   assign stat.init_zero   = (init_size == 9'd0);
   assign stat.sweep_last  = sweep_end;
   assign stat.out_free    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      head_in    = head_ff;
      empty_in   = empty_ff;
      in_use_in  = in_use_ff;
      peak_in    = peak_ff;
      granted_in = 8'd0;
      status_in  = rbpa_pkg::ST_OK;
      link_we    = 1'b0;
      link_wa    = sweep_ff[AW-1:0];
      link_wd    = {sweep_end, sweep_ff + 8'd1};
      ref_we     = 1'b0;
      ref_wa     = sweep_ff[AW-1:0];
      ref_wd     = 8'd0;
      if (cmd.sweep) begin
         link_we = 1'b1;
         ref_we  = 1'b1;
      end else if (cmd.exec) begin
         case (op_ff)
            rbpa_pkg::OP_INIT: begin
               head_in   = 8'd0;
               empty_in  = (pool_ff == 9'd0);
               in_use_in = 9'd0;
            end
            rbpa_pkg::OP_ALLOC: begin
               if (empty_ff) begin
                  status_in = rbpa_pkg::ST_OOM;
               end else begin
                  head_in    = link_q_ff[7:0];
                  empty_in   = link_q_ff[8];
                  in_use_in  = in_inc;
                  peak_in    = (in_inc > peak_ff) ? in_inc : peak_ff;
                  granted_in = head_ff;
                  ref_we     = 1'b1;
                  ref_wa     = head_ff[AW-1:0];
                  ref_wd     = 8'd1;
               end
            end
            rbpa_pkg::OP_RELEASE: begin
               if (bad_idx) begin
                  status_in = rbpa_pkg::ST_BAD;
               end else if (ref_q_ff > 8'd1) begin
                  status_in = rbpa_pkg::ST_DROPPED;
                  ref_we    = 1'b1;
                  ref_wa    = idx_ff[AW-1:0];
                  ref_wd    = ref_q_ff - 8'd1;
               end else begin
                  // last reference: push back on the free list
                  status_in = rbpa_pkg::ST_FREED;
                  link_we   = 1'b1;
                  link_wa   = idx_ff[AW-1:0];
                  link_wd   = {empty_ff, head_ff};
                  head_in   = idx_ff;
                  empty_in  = 1'b0;
                  in_use_in = in_dec;
               end
            end
            rbpa_pkg::OP_ADDREF: begin
               if (bad_idx) begin
                  status_in = rbpa_pkg::ST_BAD;
               end else if (ref_q_ff == rbpa_pkg::REF_LIMIT) begin
                  status_in = rbpa_pkg::ST_SAT;
               end else begin
                  ref_we = 1'b1;
                  ref_wa = idx_ff[AW-1:0];
                  ref_wd = ref_q_ff + 8'd1;
               end
            end
            default: begin
               status_in = rbpa_pkg::ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (cmd.capture) begin
         link_q_ff <= link_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ref_we) begin
         ref_mem[ref_wa] <= ref_wd;
      end
      if (cmd.capture) begin
         ref_q_ff <= ref_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= rbpa_pkg::TOTAL_RESET;
         pool_ff      <= 9'd0;
         head_ff      <= 8'd0;
         empty_ff     <= 1'b1;
         in_use_ff    <= 9'd0;
         peak_ff      <= 9'd0;
         sweep_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            total_ff <= csr_wr_data;
         end
         if (cmd.capture) begin
            sweep_ff <= 8'd0;
            if (req_op == rbpa_pkg::OP_INIT) begin
               pool_ff <= init_size;
            end
         end else if (cmd.sweep) begin
            sweep_ff <= sweep_ff + 8'd1;
         end
         head_ff   <= head_in;
         empty_ff  <= empty_in;
         in_use_ff <= in_use_in;
         peak_ff   <= peak_in;
         if (cmd.exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_op;
         idx_ff <= req_idx;
      end
      if (cmd.exec) begin
         granted_ff <= granted_in;
         status_ff  <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, peak_ff, in_use_ff, status_ff, granted_ff};

endmodule

### rtl/core/refcounted_block_pool_allocator.sv
// channel | direction | handshake             | payload
// req     | in        | req_tvalid/req_tready | operation, block_index
// rsp     | out       | rsp_tvalid/rsp_tready | granted_block, status, blocks_in_use, peak_in_use
// csr     | in        | csr_wr_en             | total_blocks
//
// allocate, release and add reference: accept with the link/count memory read, then
// an execute step that writes back and loads the result register
// initialize adds a sweep, unless the pool size is zero, that writes one link and count entry a cycle
// reset is synchronous and holds req_tready low; the pool holds no blocks until the first
// initialize
// one item at a time; a new item is taken while the last result still waits,
// and execute holds while that result waits with rsp_tready low
module refcounted_block_pool_allocator #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // operation[1:0], block_index[9:2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // granted_block[7:0], status[10:8],
                                     // blocks_in_use[19:11], peak_in_use[28:20]
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data   // total_blocks
);

   `include "refcounted_block_pool_allocator_macros.svh"

   rbpa_pkg::cmd_type  cmd;
   rbpa_pkg::stat_type stat;

   rbpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rbpa_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   `RBPA_ASSERT_NEXT(a_one_item, req_tvalid && req_tready, !req_tready, "item overlap")
   `RBPA_ASSERT_NOW(a_no_overwrite, cmd.exec, !rsp_tvalid || rsp_tready, "result lost")
   `RBPA_ASSERT_NOW(a_peak_bound, rsp_tvalid, rsp_tdata[28:20] >= rsp_tdata[19:11], "peak low")
   `RBPA_ASSERT_NOW(a_cmd_excl, cmd.capture, !cmd.exec && !cmd.sweep, "command clash")

endmodule
